// ===== rtl/core/ppmfd_pkg.sv =====
// Package for the PPM frame decoder: channel count, pulse limits, register map
// and stream field widths. No dependencies; imported by the decoder top level.
package ppmfd_pkg;

	localparam int CHANNELS = 8;

	// Width of a store address, and of the capture counter that must hold CHANNELS itself.
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);

	localparam int PULSE_W = 12;
	localparam int CHAN_W  = 4;
	localparam int TIME_W  = 32;
	localparam int GAP_W   = 16;
	localparam int TMO_W   = 24;

	localparam logic [PULSE_W-1:0] PULSE_MIN = PULSE_W'(800);
	localparam logic [PULSE_W-1:0] PULSE_MAX = PULSE_W'(2500);

	localparam logic [GAP_W-1:0] SYNC_GAP_RESET = GAP_W'(3000);
	localparam logic [TMO_W-1:0] TIMEOUT_RESET  = TMO_W'(100000);

	// Register map: index is paddr[2], one 32-bit word per register.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	typedef enum logic {
		REG_SYNC_GAP = 1'b0,
		REG_TIMEOUT  = 1'b1
	} reg_idx_t;

	// Stream payload widths.
	localparam int S_TDATA_W = 32;
	localparam int M_FIELD_W = CHAN_W + PULSE_W + TIME_W + 1;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;
	localparam logic MODE_EDGE    = 1'b0;
	localparam logic MODE_CHECK   = 1'b1;

endpackage

// ===== rtl/core/ppmfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used by the PPM frame decoder for its channel store.
module ppmfd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/ppm_frame_decoder_top.sv =====
// Top level of the PPM frame decoder: stream in/out, APB register port and FSM.
// Depends on ppmfd_pkg and the generic RAM ppmfd_ram holding the channel store.
//
//  Channel   Direction  Signals                        Transaction carries
//  s_*       in         s_tvalid/s_tready/s_tdata/user  one event: edge or link check
//  m_*       out        m_tvalid/m_tready/m_tdata/user  one channel value or a status
//  APB       in/out     psel/penable/pwrite/paddr/...   register writes and reads
//
// An input transaction is taken in one cycle and evaluated in the next, in ST_EVAL.
// A committing sync edge then streams CHANNELS results at one per cycle while the
// output register is free, from the channel store RAM with its single read port;
// a link check waits in ST_EVAL while the output register is stalled.
// Reset is asynchronous and active low and clears all control state; the store needs
// no clearing because a frame is only committed once every slot has been written.
// The output register lets the block take the next input while a result waits.
module ppm_frame_decoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ppmfd_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] time_us
	input  logic [0:0]                      s_tuser,  // [0] mode
	// Output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ppmfd_pkg::M_TDATA_W-1:0] m_tdata,  // [3:0] channel, [15:4] pulse_us,
	                                                  // [47:16] frame_time_us,
	                                                  // [48] connected, [55:49] zero
	output logic [0:0]                      m_tuser,  // [0] kind
	output logic                            m_tlast,
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppmfd_pkg::PADDR_W-1:0]   paddr,
	input  logic [ppmfd_pkg::PDATA_W-1:0]   pwdata,
	output logic [ppmfd_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	import ppmfd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EVAL   = 3'b010,
		ST_STREAM = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [GAP_W-1:0] sync_gap_q;
	logic [TMO_W-1:0] timeout_q;
	reg_idx_t         reg_idx;

	// Decoder state kept in flip-flops
	logic [TIME_W-1:0] last_edge_q;
	logic [TIME_W-1:0] last_frame_q;
	logic [CNT_W-1:0]  index_q;
	logic [IDX_W-1:0]  ch_q;

	// The accepted input transaction
	logic              mode_q;
	logic [TIME_W-1:0] now_q;

	// Output register
	logic               m_valid_q;
	logic               kind_q;
	logic [CHAN_W-1:0]  channel_q;
	logic [PULSE_W-1:0] pulse_q;
	logic [TIME_W-1:0]  frame_time_q;
	logic               connected_q;
	logic               last_q;

	// Datapath
	logic [TIME_W-1:0]  interval;
	logic [TIME_W-1:0]  age;
	logic               is_sync;
	logic               frame_full;
	logic               conn;
	logic [PULSE_W-1:0] clamped;
	logic               out_free;
	logic               out_load;
	logic               ch_last;

	// Channel store
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [IDX_W-1:0]   ram_raddr;
	logic [PULSE_W-1:0] ram_rdata;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_idx)
			REG_SYNC_GAP: prdata = PDATA_W'(sync_gap_q);
			REG_TIMEOUT:  prdata = PDATA_W'(timeout_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_gap_q <= SYNC_GAP_RESET;
			timeout_q  <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_SYNC_GAP: sync_gap_q <= pwdata[GAP_W-1:0];
				REG_TIMEOUT:  timeout_q  <= pwdata[TMO_W-1:0];
				default:      ;
			endcase
		end
	end

	// Both intervals are taken modulo 2^32, which plain unsigned subtraction gives.
	assign interval   = now_q - last_edge_q;
	assign age        = now_q - last_frame_q;
	assign is_sync    = interval > TIME_W'(sync_gap_q);
	assign frame_full = index_q >= CNT_W'(CHANNELS);
	assign conn       = age < TIME_W'(timeout_q);
	assign out_free   = !m_valid_q || m_tready;
	assign ch_last    = ch_q == IDX_W'(CHANNELS - 1);

	// A new result enters the output register on a link check or while streaming.
	assign out_load = out_free && (((state_q == ST_EVAL) && (mode_q == MODE_CHECK))
	                  || (state_q == ST_STREAM));

	always_comb begin
		if (interval < TIME_W'(PULSE_MIN)) begin
			clamped = PULSE_MIN;
		end else if (interval > TIME_W'(PULSE_MAX)) begin
			clamped = PULSE_MAX;
		end else begin
			clamped = interval[PULSE_W-1:0];
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// A pulse is written only while slots remain, so the counter fits the address.
	assign ram_we    = (state_q == ST_EVAL) && (mode_q == MODE_EDGE) && !is_sync
	                   && !frame_full;
	assign ram_waddr = index_q[IDX_W-1:0];

	// The read address runs one ahead of the channel being handed out, so the
	// registered read data always belongs to ch_q while streaming.
	always_comb begin
		if (state_q == ST_STREAM) begin
			ram_raddr = out_free ? IDX_W'(ch_q + 1'b1) : ch_q;
		end else begin
			ram_raddr = '0;
		end
	end

	ppmfd_ram #(
		.WIDTH(PULSE_W),
		.DEPTH(CHANNELS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(clamped),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_edge_q  <= '0;
			last_frame_q <= '0;
			index_q      <= '0;
			ch_q         <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (mode_q == MODE_CHECK) begin
						// The status result waits here until the output register frees.
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						last_edge_q <= now_q;
						if (is_sync) begin
							index_q <= '0;
							if (frame_full) begin
								last_frame_q <= now_q;
								ch_q         <= '0;
								state_q      <= ST_STREAM;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							if (!frame_full) begin
								index_q <= index_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STREAM: begin
					if (out_free) begin
						ch_q <= IDX_W'(ch_q + 1'b1);
						if (ch_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q <= s_tuser[0];
			now_q  <= s_tdata[TIME_W-1:0];
		end
		if ((state_q == ST_EVAL) && (mode_q == MODE_CHECK) && out_free) begin
			kind_q       <= KIND_STATUS;
			channel_q    <= '0;
			pulse_q      <= '0;
			frame_time_q <= last_frame_q;
			connected_q  <= conn;
			last_q       <= 1'b1;
		end else if ((state_q == ST_STREAM) && out_free) begin
			kind_q       <= KIND_CHANNEL;
			channel_q    <= CHAN_W'(ch_q);
			pulse_q      <= ram_rdata;
			frame_time_q <= last_frame_q;
			connected_q  <= 1'b0;
			last_q       <= ch_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = M_TDATA_W'({connected_q, frame_time_q, pulse_q, channel_q});

endmodule
